### hdl/i2cseq_pkg.sv
package i2cseq_pkg;

    // Default sizing of the block.
    localparam int PORTS_DEF     = 4;
    localparam int BUF_DEPTH_DEF = 256;

    // Item operations.
    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_START_WR = 3'd1;
    localparam logic [2:0] OP_START_RD = 3'd2;
    localparam logic [2:0] OP_EVENT    = 3'd3;
    localparam logic [2:0] OP_ABORT    = 3'd4;

    // Answers to a start.
    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_BAD_LEN = 2'd1;
    localparam logic [1:0] RC_NOT_EN  = 2'd2;
    localparam logic [1:0] RC_BUSY    = 2'd3;

    // Bus commands handed to the controller.
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_TX_SINGLE = 4'd1;
    localparam logic [3:0] CMD_TX_START  = 4'd2;
    localparam logic [3:0] CMD_TX_CONT   = 4'd3;
    localparam logic [3:0] CMD_TX_FINISH = 4'd4;
    localparam logic [3:0] CMD_RX_SINGLE = 4'd5;
    localparam logic [3:0] CMD_RX_START  = 4'd6;
    localparam logic [3:0] CMD_RX_CONT   = 4'd7;
    localparam logic [3:0] CMD_RX_FINISH = 4'd8;

    // Transfer state of one port.
    typedef enum logic [2:0] {
        XS_IDLE = 3'd0,
        XS_TX   = 3'd1,
        XS_RX   = 3'd2,
        XS_DONE = 3'd3,
        XS_ERR  = 3'd4
    } t_xstate;

    // Input word.
    typedef struct packed {
        logic [2:0] op;
        logic [1:0] port;
        logic [6:0] slave_address;
        logic [7:0] length;
        logic       stop_wanted;
        logic [7:0] byte_index;
        logic [7:0] byte_value;
        logic [2:0] ctrl_error;
        logic [7:0] rx_byte;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [1:0] result_code;
        logic [3:0] command;
        logic [7:0] tx_data;
        logic [6:0] addr_out;
        logic       addr_read;
        logic       addr_load;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_data;
        logic [2:0] xfer_state;
        logic       done_pulse;
        logic [2:0] error_bits;
    } t_out_word;

    // One entry of the per-port context memory.
    typedef struct packed {
        t_xstate    state;
        logic [7:0] position;
        logic [7:0] length;
        logic       stop;
        logic [2:0] saved_error;
    } t_ctx;

    // Write strobes from the step logic to the memories.
    typedef struct packed {
        logic ctx_we;
        logic buf_we;
    } t_step_ctl;

endpackage

### hdl/i2cseq_ctx_mem.sv
module i2cseq_ctx_mem #(
    parameter int PORTS   = 4,
    parameter int PIDX_W  = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [PIDX_W-1:0]     i_rd_addr,
    output i2cseq_pkg::t_ctx      o_rd_data,
    input  logic                  i_wr_en,
    input  logic [PIDX_W-1:0]     i_wr_addr,
    input  i2cseq_pkg::t_ctx      i_wr_data
);
    import i2cseq_pkg::*;

    t_ctx             r_mem [PORTS];
    logic [PORTS-1:0] r_valid;
    t_ctx             r_rd_data;
    logic             r_rd_valid;

    // Valid bits: an entry never written reads as the reset context.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en && (32'(i_wr_addr) < PORTS)) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= (32'(i_rd_addr) < PORTS) && r_valid[i_rd_addr];
            end
        end
    end

    // Storage array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (32'(i_wr_addr) < PORTS)) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en && (32'(i_rd_addr) < PORTS)) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### hdl/i2cseq_tx_buf.sv
module i2cseq_tx_buf #(
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data
);
    localparam int DEPTH = 1 << AW;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Transmit bytes of all ports, one region per port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/i2cseq_step.sv
module i2cseq_step #(
    parameter int BUF_DEPTH = 256
) (
    input  i2cseq_pkg::t_in_word  i_item,
    input  i2cseq_pkg::t_ctx      i_ctx,
    input  logic                  i_port_ok,
    input  logic                  i_port_en,
    input  logic [7:0]            i_tx_byte,
    output i2cseq_pkg::t_out_word o_res,
    output i2cseq_pkg::t_ctx      o_ctx,
    output i2cseq_pkg::t_step_ctl o_ctl
);
    import i2cseq_pkg::*;

    logic w_active;
    logic w_adv;
    t_ctx w_ctx;

    assign w_active = (i_ctx.state == XS_TX) || (i_ctx.state == XS_RX);

    always_comb begin
        o_res = '0;
        o_ctl = '0;
        w_ctx = i_ctx;
        w_adv = 1'b0;

        // Dispatch on the operation; start checks run in order.
        if ((i_item.op == OP_START_WR) || (i_item.op == OP_START_RD)) begin
            if (!i_port_ok || !i_port_en) begin
                o_res.result_code = RC_NOT_EN;
            end else if ((i_item.length == 8'd0) ||
                         (9'(i_item.length) > 9'(BUF_DEPTH))) begin
                o_res.result_code = RC_BAD_LEN;
            end else if (w_active) begin
                o_res.result_code = RC_BUSY;
            end else begin
                w_ctx.state       = (i_item.op == OP_START_WR) ? XS_TX : XS_RX;
                w_ctx.position    = 8'd0;
                w_ctx.length      = i_item.length;
                w_ctx.stop        = i_item.stop_wanted;
                w_ctx.saved_error = 3'd0;
                o_res.addr_out    = i_item.slave_address;
                o_res.addr_read   = (i_item.op == OP_START_RD);
                o_res.addr_load   = 1'b1;
                o_ctl.ctx_we      = 1'b1;
                w_adv             = 1'b1;
            end
        end else if (i_port_ok) begin
            if (i_item.op == OP_LOAD) begin
                o_ctl.buf_we = (9'(i_item.byte_index) < 9'(BUF_DEPTH));
            end else if ((i_item.op == OP_EVENT) && w_active) begin
                o_ctl.ctx_we = 1'b1;
                w_adv        = 1'b1;
            end else if ((i_item.op == OP_ABORT) && w_active) begin
                w_ctx.state      = XS_ERR;
                o_res.done_pulse = 1'b1;
                o_ctl.ctx_we     = 1'b1;
            end
        end

        // Advance the active transfer by one controller event.
        if (w_adv) begin
            if (i_item.ctrl_error != 3'd0) begin
                w_ctx.saved_error = i_item.ctrl_error;
                w_ctx.state       = XS_ERR;
                o_res.done_pulse  = 1'b1;
            end else if (w_ctx.state == XS_TX) begin
                if (w_ctx.position >= w_ctx.length) begin
                    w_ctx.state      = XS_DONE;
                    o_res.done_pulse = 1'b1;
                end else begin
                    o_res.tx_data = i_tx_byte;
                    if (w_ctx.length == 8'd1) begin
                        o_res.command = w_ctx.stop ? CMD_TX_SINGLE : CMD_TX_START;
                    end else if (w_ctx.position == 8'd0) begin
                        o_res.command = CMD_TX_START;
                    end else if (w_ctx.position == w_ctx.length - 8'd1) begin
                        o_res.command = w_ctx.stop ? CMD_TX_FINISH : CMD_TX_CONT;
                    end else begin
                        o_res.command = CMD_TX_CONT;
                    end
                    w_ctx.position = w_ctx.position + 8'd1;
                end
            end else begin
                // Receive: hand out the byte that the last command fetched.
                if ((w_ctx.position != 8'd0) && (w_ctx.position <= w_ctx.length)) begin
                    o_res.rx_valid = 1'b1;
                    o_res.rx_index = w_ctx.position - 8'd1;
                    o_res.rx_data  = i_item.rx_byte;
                end
                if (w_ctx.position >= w_ctx.length) begin
                    w_ctx.state      = XS_DONE;
                    o_res.done_pulse = 1'b1;
                end else begin
                    if (w_ctx.length == 8'd1) begin
                        o_res.command = CMD_RX_SINGLE;
                    end else if (w_ctx.position == 8'd0) begin
                        o_res.command = CMD_RX_START;
                    end else if (w_ctx.position == w_ctx.length - 8'd1) begin
                        o_res.command = CMD_RX_FINISH;
                    end else begin
                        o_res.command = CMD_RX_CONT;
                    end
                    w_ctx.position = w_ctx.position + 8'd1;
                end
            end
        end

        // Report the port as it stands after the step.
        if (i_port_ok) begin
            o_res.xfer_state = w_ctx.state;
            o_res.error_bits = w_ctx.saved_error;
        end
    end

    assign o_ctx = w_ctx;

endmodule

### hdl/i2c_master_transfer_sequencer_top.sv
// Channel   Valid        Stall        Word
// input     i_in_valid   o_in_stall   i_in_data  (t_in_word)
// output    o_out_valid  i_out_stall  o_out_data (t_out_word)
// config    i_cfg_we     -            i_cfg_wdata
//
// Each word is accepted in S_IDLE, which reads the port context memory;
// S_FETCH reads the transmit buffer at the position found there, and
// S_EXEC computes the step, writes back and loads the output register.
// The buffer read is chained behind the context read.
// Reset clears the FSM, the output valid, the enable mask and the context
// valid bits; buffer bytes stay undefined until loaded. A stalled output
// holds the step in S_EXEC until the output register frees up.
module i2c_master_transfer_sequencer_top #(
    parameter int PORTS     = i2cseq_pkg::PORTS_DEF,
    parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2cseq_pkg::t_in_word  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cseq_pkg::t_out_word o_out_data,
    input  logic                  i_cfg_we,
    input  logic [3:0]            i_cfg_wdata
);
    import i2cseq_pkg::*;

    localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int BW     = $clog2(BUF_DEPTH);
    localparam int AW     = PIDX_W + BW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    t_state              r_state;
    t_in_word            r_item;
    logic                r_out_valid;
    t_out_word           r_out_data;
    logic [3:0]          r_mask;

    logic                w_accept;
    logic                w_exec;
    logic [PIDX_W+1:0]   w_in_port_ext;
    logic [PIDX_W+1:0]   w_item_port_ext;
    logic [PIDX_W-1:0]   w_in_pidx;
    logic [PIDX_W-1:0]   w_item_pidx;
    logic                w_port_ok;
    t_ctx                w_ctx_rd;
    t_ctx                w_ctx_wr;
    logic [BW-1:0]       w_rd_pos;
    logic [7:0]          w_tx_byte;
    t_out_word           w_res;
    t_step_ctl           w_ctl;

    // The input is held off while reset is applied and while a word is in work.
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_exec     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // Port numbers narrowed to the memory index width.
    assign w_in_port_ext   = (PIDX_W + 2)'(i_in_data.port);
    assign w_item_port_ext = (PIDX_W + 2)'(r_item.port);
    assign w_in_pidx       = w_in_port_ext[PIDX_W-1:0];
    assign w_item_pidx     = w_item_port_ext[PIDX_W-1:0];
    assign w_port_ok       = (32'(r_item.port) < PORTS);

    // A start sends from the head of the buffer.
    assign w_rd_pos = ((r_item.op == OP_START_WR) || (r_item.op == OP_START_RD)) ?
                      '0 : w_ctx_rd.position[BW-1:0];

    i2cseq_ctx_mem #(
        .PORTS  (PORTS),
        .PIDX_W (PIDX_W)
    ) u_ctx_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_pidx),
        .o_rd_data (w_ctx_rd),
        .i_wr_en   (w_exec && w_ctl.ctx_we),
        .i_wr_addr (w_item_pidx),
        .i_wr_data (w_ctx_wr)
    );

    i2cseq_tx_buf #(
        .AW (AW)
    ) u_tx_buf (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_FETCH),
        .i_rd_addr ({w_item_pidx, w_rd_pos}),
        .o_rd_data (w_tx_byte),
        .i_wr_en   (w_exec && w_ctl.buf_we),
        .i_wr_addr ({w_item_pidx, r_item.byte_index[BW-1:0]}),
        .i_wr_data (r_item.byte_value)
    );

    i2cseq_step #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_step (
        .i_item    (r_item),
        .i_ctx     (w_ctx_rd),
        .i_port_ok (w_port_ok),
        .i_port_en (r_mask[r_item.port]),
        .i_tx_byte (w_tx_byte),
        .o_res     (w_res),
        .o_ctx     (w_ctx_wr),
        .o_ctl     (w_ctl)
    );

    // Sequencer FSM, configuration register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mask      <= 4'd0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            // A new result refills the register; otherwise a taken result empties it.
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_exec) begin
                        r_out_data <= w_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### test/tb_i2c_master_transfer_sequencer_top.sv
`timescale 1ns / 1ps

module tb_i2c_master_transfer_sequencer_top;
    import i2cseq_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic clk;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;

    i2c_master_transfer_sequencer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 10 ns clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Per-port transfer contexts as the block should hold them.
    logic [3:0] enable_mask = 4'd0;
    t_xstate    port_st   [PORTS_DEF];
    logic [7:0] xfer_pos  [PORTS_DEF];
    logic [7:0] xfer_len  [PORTS_DEF];
    logic       xfer_stop [PORTS_DEF];
    logic [2:0] port_err  [PORTS_DEF];
    logic [7:0] tx_mem    [PORTS_DEF][BUF_DEPTH_DEF];

    // Buffer bytes already loaded, tracked as words are queued.
    bit loaded [PORTS_DEF][BUF_DEPTH_DEF];

    t_in_word  pending_words [$];
    t_out_word due_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_words = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_ended = 0;
    int n_settings = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // One controller event on an active transfer: error check, received byte,
    // then the next bus command or completion.
    function automatic void advance_transfer(input int p, input logic [2:0] err,
                                             input logic [7:0] rxb,
                                             inout t_out_word r);
        logic [7:0] cur;
        logic [7:0] total;
        cur = xfer_pos[p];
        total = xfer_len[p];
        if (err != 3'd0) begin
            port_err[p] = err;
            port_st[p] = XS_ERR;
            r.done_pulse = 1'b1;
        end else if (port_st[p] == XS_TX) begin
            if (cur >= total) begin
                port_st[p] = XS_DONE;
                r.done_pulse = 1'b1;
            end else begin
                r.tx_data = tx_mem[p][cur];
                if (total == 8'd1)
                    r.command = xfer_stop[p] ? CMD_TX_SINGLE : CMD_TX_START;
                else if (cur == 8'd0)
                    r.command = CMD_TX_START;
                else if (cur == total - 8'd1)
                    r.command = xfer_stop[p] ? CMD_TX_FINISH : CMD_TX_CONT;
                else
                    r.command = CMD_TX_CONT;
                xfer_pos[p] = cur + 8'd1;
            end
        end else begin
            // Receive: the byte fetched by the previous command is handed out first.
            if (cur != 8'd0 && cur <= total) begin
                r.rx_valid = 1'b1;
                r.rx_index = cur - 8'd1;
                r.rx_data = rxb;
            end
            if (cur >= total) begin
                port_st[p] = XS_DONE;
                r.done_pulse = 1'b1;
            end else begin
                if (total == 8'd1)
                    r.command = CMD_RX_SINGLE;
                else if (cur == 8'd0)
                    r.command = CMD_RX_START;
                else if (cur == total - 8'd1)
                    r.command = CMD_RX_FINISH;
                else
                    r.command = CMD_RX_CONT;
                xfer_pos[p] = cur + 8'd1;
            end
        end
    endfunction

    // Result word for one accepted input word; updates the port contexts.
    function automatic t_out_word next_result(input t_in_word w);
        t_out_word r;
        int p;
        r = '0;
        p = int'(w.port);
        if (w.op == OP_START_WR || w.op == OP_START_RD) begin
            if (!enable_mask[p]) begin
                r.result_code = RC_NOT_EN;
            end else if (w.length == 8'd0) begin
                r.result_code = RC_BAD_LEN;
            end else if (port_st[p] == XS_TX || port_st[p] == XS_RX) begin
                r.result_code = RC_BUSY;
            end else begin
                port_st[p] = (w.op == OP_START_WR) ? XS_TX : XS_RX;
                xfer_pos[p] = 8'd0;
                xfer_len[p] = w.length;
                xfer_stop[p] = w.stop_wanted;
                port_err[p] = 3'd0;
                r.addr_out = w.slave_address;
                r.addr_read = (w.op == OP_START_RD);
                r.addr_load = 1'b1;
                advance_transfer(p, w.ctrl_error, w.rx_byte, r);
            end
        end else if (w.op == OP_LOAD) begin
            tx_mem[p][w.byte_index] = w.byte_value;
        end else if (w.op == OP_EVENT) begin
            if (port_st[p] == XS_TX || port_st[p] == XS_RX)
                advance_transfer(p, w.ctrl_error, w.rx_byte, r);
        end else if (w.op == OP_ABORT) begin
            if (port_st[p] == XS_TX || port_st[p] == XS_RX) begin
                port_st[p] = XS_ERR;
                r.done_pulse = 1'b1;
            end
        end
        r.xfer_state = port_st[p];
        r.error_bits = port_err[p];
        return r;
    endfunction

    function automatic string describe(input t_out_word w);
        return $sformatf({"rc=%0d cmd=%0d tx=%02h addr=%02h rd=%0b ld=%0b rxv=%0b ",
                          "rxi=%0d rxd=%02h st=%0d done=%0b err=%0d"},
                         w.result_code, w.command, w.tx_data, w.addr_out, w.addr_read,
                         w.addr_load, w.rx_valid, w.rx_index, w.rx_data, w.xfer_state,
                         w.done_pulse, w.error_bits);
    endfunction

    // Word with random content, the given op and port, and no controller error.
    function automatic t_in_word make_word(input logic [2:0] op, input logic [1:0] port);
        logic [63:0] bits;
        t_in_word w;
        bits = {$urandom, $urandom};
        w = bits[$bits(t_in_word)-1:0];
        w.op = op;
        w.port = port;
        w.ctrl_error = 3'd0;
        return w;
    endfunction

    // Queue a word. A write start is preceded by loads of any buffer byte it
    // could send that was never written.
    function automatic void queue_word(input t_in_word w);
        t_in_word ld;
        if (w.op == OP_START_WR) begin
            for (int i = 0; i < w.length; i++) begin
                if (!loaded[w.port][i]) begin
                    ld = make_word(OP_LOAD, w.port);
                    ld.byte_index = 8'(i);
                    pending_words.push_back(ld);
                    loaded[w.port][i] = 1'b1;
                    phase_words++;
                end
            end
        end else if (w.op == OP_LOAD) begin
            loaded[w.port][w.byte_index] = 1'b1;
        end
        pending_words.push_back(w);
        phase_words++;
    endfunction

    function automatic void queue_start(input logic [2:0] op, input logic [1:0] port,
                                        input logic [7:0] len, input logic stop,
                                        input logic [6:0] addr, input logic [2:0] err);
        t_in_word w;
        w = make_word(op, port);
        w.length = len;
        w.stop_wanted = stop;
        w.slave_address = addr;
        w.ctrl_error = err;
        queue_word(w);
    endfunction

    function automatic void queue_event(input logic [1:0] port, input logic [2:0] err,
                                        input logic [7:0] rxb);
        t_in_word w;
        w = make_word(OP_EVENT, port);
        w.ctrl_error = err;
        w.rx_byte = rxb;
        queue_word(w);
    endfunction

    // Mostly enabled ports while any are enabled.
    function automatic logic [1:0] pick_port();
        logic [1:0] p;
        p = 2'($urandom_range(0, 3));
        if (enable_mask != 4'd0 && $urandom_range(0, 9) != 0)
            while (!enable_mask[p])
                p = 2'($urandom_range(0, 3));
        return p;
    endfunction

    // Short transfers mostly, a few medium, rare long ones and some of zero length.
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 8'd0;
        else if (r < 4)
            return 8'($urandom_range(33, 255));
        else if (r < 10)
            return 8'($urandom_range(9, 32));
        return 8'($urandom_range(1, 8));
    endfunction

    function automatic logic [2:0] pick_err();
        return ($urandom_range(0, 19) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    endfunction

    // Arbitrary word on any port, unused ops included.
    function automatic void add_noise();
        t_in_word w;
        w = make_word(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        w.ctrl_error = 3'($urandom_range(0, 7));
        if ((w.op == OP_START_WR || w.op == OP_START_RD) && $urandom_range(0, 29) != 0)
            w.length = 8'($urandom_range(0, 8));
        queue_word(w);
    endfunction

    // A well-formed transfer: start, then enough events to finish it, with
    // stray words, errors and an occasional timeout mixed in.
    function automatic void add_transfer();
        logic [1:0] p;
        logic [7:0] len;
        int n_ev;
        p = pick_port();
        len = pick_len();
        if ($urandom_range(0, 3) == 0)
            queue_word(make_word(OP_LOAD, p));
        queue_start($urandom_range(0, 1) ? OP_START_WR : OP_START_RD, p, len,
                    1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), pick_err());
        n_ev = len + $urandom_range(0, 1);
        for (int i = 0; i < n_ev; i++) begin
            if ($urandom_range(0, 9) == 0)
                add_noise();
            if ($urandom_range(0, 59) == 0) begin
                queue_word(make_word(OP_ABORT, p));
                break;
            end
            queue_event(p, pick_err(), 8'($urandom_range(0, 255)));
        end
    endfunction

    // Wait until every queued word has been answered, let the block settle,
    // write the enable mask and set the idling of the next phase.
    task automatic set_phase(input logic [3:0] mask, input int send_pct, input int stall_pct);
        while (pending_words.size() != 0 || due_results.size() != 0 || in_valid)
            @(negedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_we <= 1'b0;
        enable_mask = mask;
        n_settings++;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        phase_words = 0;
    endtask

    task automatic run_random(input logic [3:0] mask, input int send_pct,
                              input int stall_pct, input int n_words);
        set_phase(mask, send_pct, stall_pct);
        while (phase_words < n_words) begin
            if ($urandom_range(0, 4) == 0)
                add_noise();
            else
                add_transfer();
        end
    endtask

    // Driver: present queued words, predict each one as it is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                due_results.push_back(next_result(in_data));
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pending_words.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, each accepted result against the oldest prediction.
    always @(posedge clk) begin : monitor
        t_out_word exp_w;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result word with nothing predicted: %s",
                                 describe(out_data));
                end else begin
                    exp_w = due_results.pop_front();
                    n_checked++;
                    if (exp_w.done_pulse)
                        n_ended++;
                    if (out_data !== exp_w) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result word %0d differs", n_checked);
                            $display("  expected %s", describe(exp_w));
                            $display("  actual   %s", describe(out_data));
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without a word moving on either side ends the run.
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
            $display("i2c_master_transfer_sequencer_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_in_word w;
        foreach (port_st[i]) begin
            port_st[i] = XS_IDLE;
            xfer_pos[i] = 8'd0;
            xfer_len[i] = 8'd0;
            xfer_stop[i] = 1'b0;
            port_err[i] = 3'd0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Nothing enabled: a start is refused, an event is ignored.
        set_phase(4'd0, 0, 0);
        queue_start(OP_START_WR, 2'd0, 8'd4, 1'b1, 7'd9, 3'd0);
        queue_event(2'd3, 3'd0, 8'h00);

        // All ports enabled: directed walk through the commands and corner cases.
        set_phase(4'hF, 0, 0);
        queue_start(OP_START_WR, 2'd1, 8'd0, 1'b1, 7'd1, 3'd0);
        w = make_word(OP_LOAD, 2'd1);
        w.byte_index = 8'd0;
        w.byte_value = 8'hFF;
        queue_word(w);
        w = make_word(OP_LOAD, 2'd1);
        w.byte_index = 8'd255;
        w.byte_value = 8'h00;
        queue_word(w);
        // Single-byte write, a start while it is busy, then completion.
        queue_start(OP_START_WR, 2'd1, 8'd1, 1'b1, 7'd0, 3'd0);
        queue_start(OP_START_RD, 2'd1, 8'd2, 1'b0, 7'd3, 3'd0);
        queue_event(2'd1, 3'd0, 8'h00);
        // Three-byte write that keeps the bus.
        queue_start(OP_START_WR, 2'd2, 8'd3, 1'b0, 7'd127, 3'd0);
        repeat (3) queue_event(2'd2, 3'd0, 8'hFF);
        // Two-byte write with a stop.
        queue_start(OP_START_WR, 2'd0, 8'd2, 1'b1, 7'h2A, 3'd0);
        repeat (2) queue_event(2'd0, 3'd0, 8'h11);
        // Reads of two and one byte; the stop request does not matter here.
        queue_start(OP_START_RD, 2'd3, 8'd2, 1'b1, 7'h55, 3'd0);
        queue_event(2'd3, 3'd0, 8'hA5);
        queue_event(2'd3, 3'd0, 8'h5A);
        queue_start(OP_START_RD, 2'd3, 8'd1, 1'b0, 7'h00, 3'd0);
        queue_event(2'd3, 3'd0, 8'hFF);
        // Longest read, aborted by a timeout; a second timeout does nothing.
        queue_start(OP_START_RD, 2'd2, 8'd255, 1'b0, 7'h7F, 3'd0);
        queue_event(2'd2, 3'd0, 8'h3C);
        queue_word(make_word(OP_ABORT, 2'd2));
        queue_word(make_word(OP_ABORT, 2'd2));
        // Start that fails on its own error bits, then an event on the failed port.
        queue_start(OP_START_WR, 2'd1, 8'd1, 1'b1, 7'h40, 3'd7);
        queue_event(2'd1, 3'd0, 8'h00);
        // Data nack in the middle of a read.
        queue_start(OP_START_RD, 2'd0, 8'd3, 1'b0, 7'h12, 3'd0);
        queue_event(2'd0, 3'd2, 8'h99);
        // Unused ops.
        queue_word(make_word(3'd5, 2'd0));
        queue_word(make_word(3'd6, 2'd1));
        queue_word(make_word(3'd7, 2'd2));

        // Random phases under the various idling patterns and enable settings.
        run_random(4'hF, 0, 0, 150);
        run_random(4'hF, 72, 0, 150);
        run_random(4'($urandom_range(1, 14)), 0, 72, 150);
        run_random(4'h5, 8, 8, 150);
        run_random(4'h0, 0, 0, 40);
        run_random(4'hF, 8, 8, 160);

        while (pending_words.size() != 0 || due_results.size() != 0 || in_valid)
            @(negedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d words under %0d enable settings; checked %0d results,",
                 n_accepted, n_settings, n_checked);
        $display("%0d of which ended a transfer, %0d mismatches.", n_ended, mismatches);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("i2c_master_transfer_sequencer_top test passed");
        end else begin
            $display("i2c_master_transfer_sequencer_top test failed");
        end
        $finish;
    end

endmodule
